// ===== hw/rtl/dec_pkg.sv =====
package dec_pkg;

    localparam int WORD_W   = 32;
    localparam int FRAC     = 16;
    localparam int RAD_W    = WORD_W - 1;
    localparam int NRM_W    = FRAC + 2;
    localparam int ROT_W    = WORD_W + 3;
    localparam int Q_W      = WORD_W + 2;
    localparam int SAT_W    = ROT_W + 3;
    localparam int DIV_Q    = WORD_W + 1;
    localparam int DIV_D    = ROT_W + 1;
    localparam int DIV_R    = DIV_D + 1;
    localparam int DIV_N    = ROT_W + FRAC + 1;
    localparam int SQ_W     = 2 * WORD_W;
    localparam int SQ_STEPS = WORD_W;
    localparam int SQ_REM   = WORD_W + 4;
    localparam int LONG_LAT = DIV_Q;

    localparam logic signed [NRM_W-1:0] NRM_ONE = {2'b01, {FRAC{1'b0}}};

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [NRM_W-1:0]  t_nrm;
    typedef logic signed [ROT_W-1:0]  t_rot;

    typedef struct packed {
        t_word              p1x;
        t_word              p1y;
        t_word              v1x;
        t_word              v1y;
        t_word              v2x;
        t_word              v2y;
        logic [WORD_W-1:0]  s;
        logic               hit;
        logic               sx;
        logic               sy;
        logic [WORD_W-1:0]  adx;
        logic [WORD_W-1:0]  ady;
        logic [WORD_W-1:0]  dlen;
        t_nrm               nx;
        t_nrm               ny;
        t_rot               a;
        t_rot               b;
        t_rot               t1;
        t_rot               t2;
        logic               skip;
    } t_item;

    typedef struct packed {
        logic   collided;
        t_word  npx;
        t_word  npy;
        t_word  nv1x;
        t_word  nv1y;
        t_word  nv2x;
        t_word  nv2y;
        logic   skipped;
    } t_res;

    function automatic t_word sat_word(input logic signed [SAT_W-1:0] x);
        logic [SAT_W-WORD_W:0] top;
        top = x[SAT_W-1:WORD_W-1];
        if (top == '0 || top == '1) begin
            return t_word'(x[WORD_W-1:0]);
        end else if (x[SAT_W-1]) begin
            return {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            return {1'b0, {(WORD_W-1){1'b1}}};
        end
    endfunction

endpackage

// ===== hw/rtl/disc_elastic_collision.sv =====
// Channel  Direction  Handshake           Payload
// input    in         i_valid / o_ready   i_first_pos_x .. i_second_radius
// output   out        o_valid / i_ready   o_collided .. o_push_skipped
//
// One disc pair is accepted per cycle while the output side keeps up.
// A result beat passes through one square root and three divider levels of 33 stages each
// (the nx and ny dividers run side by side), plus the compare, rotation and push stages.
// Reset is synchronous and clears only the valid bits of the pipeline, the output and the skid register.
// A stalled output holds its beat and a skid register catches one more beat;
// the whole pipeline then freezes until the skid register drains.
module disc_elastic_collision import dec_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_word               i_first_pos_x,
    input  t_word               i_first_pos_y,
    input  t_word               i_second_pos_x,
    input  t_word               i_second_pos_y,
    input  t_word               i_first_vel_x,
    input  t_word               i_first_vel_y,
    input  t_word               i_second_vel_x,
    input  t_word               i_second_vel_y,
    input  logic [RAD_W-1:0]    i_first_radius,
    input  logic [RAD_W-1:0]    i_second_radius,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_collided,
    output t_word               o_new_first_pos_x,
    output t_word               o_new_first_pos_y,
    output t_word               o_new_first_vel_x,
    output t_word               o_new_first_vel_y,
    output t_word               o_new_second_vel_x,
    output t_word               o_new_second_vel_y,
    output logic                o_push_skipped
);

    logic              en;
    logic              f_vld, s_vld, n_vld, rt_vld, ra_vld, qm_vld, tail_vld;
    t_item             f_item, s_item, norm_item, n_item, rt_item, ra_item, qm_item;
    logic [SQ_W-1:0]   sumsq;
    logic [WORD_W-1:0] root;
    logic [DIV_Q-1:0]  nx_mag, ny_mag, ratio, qm;
    logic [DIV_N-1:0]  rnum;
    logic [DIV_D-1:0]  rden;
    t_res              tail;
    t_res              r_out, r_skid;
    logic              r_out_vld, r_skid_vld;

    assign en = !r_skid_vld;

    dec_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_p1x   (i_first_pos_x),
        .i_p1y   (i_first_pos_y),
        .i_p2x   (i_second_pos_x),
        .i_p2y   (i_second_pos_y),
        .i_v1x   (i_first_vel_x),
        .i_v1y   (i_first_vel_y),
        .i_v2x   (i_second_vel_x),
        .i_v2y   (i_second_vel_y),
        .i_r1    (i_first_radius),
        .i_r2    (i_second_radius),
        .o_valid (f_vld),
        .o_item  (f_item),
        .o_sumsq (sumsq)
    );

    dec_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (sumsq),
        .o_root (root)
    );

    dec_dly u_dly_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_vld),
        .i_item  (f_item),
        .o_valid (s_vld),
        .o_item  (s_item)
    );

    always_comb begin
        norm_item = s_item;
        norm_item.dlen = root;
    end

    dec_div u_div_nx (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (DIV_N'({s_item.adx, {FRAC{1'b0}}})),
        .i_den  (DIV_D'(root)),
        .o_quot (nx_mag)
    );

    dec_div u_div_ny (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (DIV_N'({s_item.ady, {FRAC{1'b0}}})),
        .i_den  (DIV_D'(root)),
        .o_quot (ny_mag)
    );

    dec_dly u_dly_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_vld),
        .i_item  (norm_item),
        .o_valid (n_vld),
        .o_item  (n_item)
    );

    dec_rot u_rot (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (n_vld),
        .i_item   (n_item),
        .i_nx_mag (nx_mag),
        .i_ny_mag (ny_mag),
        .o_valid  (rt_vld),
        .o_item   (rt_item),
        .o_rnum   (rnum),
        .o_rden   (rden)
    );

    dec_div u_div_ratio (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (rnum),
        .i_den  (rden),
        .o_quot (ratio)
    );

    dec_dly u_dly_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (rt_vld),
        .i_item  (rt_item),
        .o_valid (ra_vld),
        .o_item  (ra_item)
    );

    dec_div u_div_push (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (DIV_N'({ratio[FRAC:0], {FRAC{1'b0}}})),
        .i_den  (DIV_D'(ra_item.s - ra_item.dlen)),
        .o_quot (qm)
    );

    dec_dly u_dly_push (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (ra_vld),
        .i_item  (ra_item),
        .o_valid (qm_vld),
        .o_item  (qm_item)
    );

    dec_push u_push (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (qm_vld),
        .i_item  (qm_item),
        .i_qm    (qm),
        .o_valid (tail_vld),
        .o_res   (tail)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || i_ready) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= tail_vld;
            end
        end else if (tail_vld && en) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || i_ready) begin
            if (r_skid_vld) begin
                r_out <= r_skid;
            end else begin
                r_out <= tail;
            end
        end else if (tail_vld && en) begin
            r_skid <= tail;
        end
    end

    assign o_ready            = en;
    assign o_valid            = r_out_vld;
    assign o_collided         = r_out.collided;
    assign o_new_first_pos_x  = r_out.npx;
    assign o_new_first_pos_y  = r_out.npy;
    assign o_new_first_vel_x  = r_out.nv1x;
    assign o_new_first_vel_y  = r_out.nv1y;
    assign o_new_second_vel_x = r_out.nv2x;
    assign o_new_second_vel_y = r_out.nv2y;
    assign o_push_skipped     = r_out.skipped;

endmodule

// ===== hw/rtl/dec_front.sv =====
module dec_front import dec_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  t_word               i_p1x,
    input  t_word               i_p1y,
    input  t_word               i_p2x,
    input  t_word               i_p2y,
    input  t_word               i_v1x,
    input  t_word               i_v1y,
    input  t_word               i_v2x,
    input  t_word               i_v2y,
    input  logic [RAD_W-1:0]    i_r1,
    input  logic [RAD_W-1:0]    i_r2,
    output logic                o_valid,
    output t_item               o_item,
    output logic [SQ_W-1:0]     o_sumsq
);

    localparam int DW = WORD_W + 1;

    logic              r1_vld, r2_vld, r3_vld;
    t_item             r1_item, r2_item, r3_item;
    logic [DW-1:0]     r1_adx, r1_ady;
    logic [SQ_W-1:0]   r2_sqx, r2_sqy, r2_ss, r3_sumsq;
    logic              r2_ltx, r2_lty;

    logic signed [DW-1:0] dx, dy;
    logic [DW-1:0]        adx, ady;
    t_item                c1_item, c2_item, c3_item;
    logic [SQ_W:0]        sum;

    always_comb begin
        dx = DW'(i_p1x) - DW'(i_p2x);
        dy = DW'(i_p1y) - DW'(i_p2y);
        adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
        ady = dy[DW-1] ? DW'(-dy) : DW'(dy);
        c1_item = '0;
        c1_item.p1x = i_p1x;
        c1_item.p1y = i_p1y;
        c1_item.v1x = i_v1x;
        c1_item.v1y = i_v1y;
        c1_item.v2x = i_v2x;
        c1_item.v2y = i_v2y;
        c1_item.s = WORD_W'(i_r1) + WORD_W'(i_r2);
        c1_item.sx = dx[DW-1];
        c1_item.sy = dy[DW-1];

        c2_item = r1_item;
        c2_item.adx = r1_adx[WORD_W-1:0];
        c2_item.ady = r1_ady[WORD_W-1:0];

        sum = {1'b0, r2_sqx} + {1'b0, r2_sqy};
        c3_item = r2_item;
        c3_item.hit = r2_ltx & r2_lty & (sum < {1'b0, r2_ss});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_item   <= c1_item;
            r1_adx    <= adx;
            r1_ady    <= ady;
            r2_item   <= c2_item;
            r2_sqx    <= r1_adx[WORD_W-1:0] * r1_adx[WORD_W-1:0];
            r2_sqy    <= r1_ady[WORD_W-1:0] * r1_ady[WORD_W-1:0];
            r2_ss     <= r1_item.s * r1_item.s;
            r2_ltx    <= r1_adx < {1'b0, r1_item.s};
            r2_lty    <= r1_ady < {1'b0, r1_item.s};
            r3_item   <= c3_item;
            r3_sumsq  <= sum[SQ_W-1:0];
        end
    end

    assign o_valid = r3_vld;
    assign o_item  = r3_item;
    assign o_sumsq = r3_sumsq;

endmodule

// ===== hw/rtl/dec_sqrt.sv =====
module dec_sqrt import dec_pkg::*; (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [SQ_W-1:0]     i_rad,
    output logic [WORD_W-1:0]   o_root
);

    logic [SQ_REM-1:0] r_rem  [SQ_STEPS];
    logic [SQ_W-1:0]   r_bits [SQ_STEPS];
    logic [WORD_W-1:0] r_root [SQ_STEPS];
    logic [SQ_REM-1:0] n_rem  [SQ_STEPS];
    logic [SQ_W-1:0]   n_bits [SQ_STEPS];
    logic [WORD_W-1:0] n_root [SQ_STEPS];
    logic [WORD_W-1:0] r_out;

    always_comb begin
        logic [SQ_REM-1:0] rem;
        logic [SQ_REM-1:0] trial;
        logic [SQ_W-1:0]   bits;
        logic [WORD_W-1:0] root;
        for (int j = 0; j < SQ_STEPS; j++) begin
            if (j == 0) begin
                rem  = '0;
                bits = i_rad;
                root = '0;
            end else begin
                rem  = r_rem[j-1];
                bits = r_bits[j-1];
                root = r_root[j-1];
            end
            rem   = {rem[SQ_REM-3:0], bits[SQ_W-1:SQ_W-2]};
            trial = SQ_REM'({root, 2'b01});
            if (rem >= trial) begin
                rem  = rem - trial;
                root = {root[WORD_W-2:0], 1'b1};
            end else begin
                root = {root[WORD_W-2:0], 1'b0};
            end
            n_rem[j]  = rem;
            n_bits[j] = {bits[SQ_W-3:0], 2'b00};
            n_root[j] = root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_bits <= n_bits;
            r_root <= n_root;
            r_out  <= r_root[SQ_STEPS-1];
        end
    end

    assign o_root = r_out;

endmodule

// ===== hw/rtl/dec_div.sv =====
module dec_div import dec_pkg::*; (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [DIV_N-1:0]    i_num,
    input  logic [DIV_D-1:0]    i_den,
    output logic [DIV_Q-1:0]    o_quot
);

    logic [DIV_R-1:0] r_rem  [DIV_Q];
    logic [DIV_Q-1:0] r_bits [DIV_Q];
    logic [DIV_D-1:0] r_den  [DIV_Q];
    logic [DIV_Q-1:0] r_quo  [DIV_Q];
    logic [DIV_R-1:0] n_rem  [DIV_Q];
    logic [DIV_Q-1:0] n_bits [DIV_Q];
    logic [DIV_D-1:0] n_den  [DIV_Q];
    logic [DIV_Q-1:0] n_quo  [DIV_Q];

    always_comb begin
        logic [DIV_R-1:0] rem;
        logic [DIV_Q-1:0] bits;
        logic [DIV_D-1:0] den;
        logic [DIV_Q-1:0] quo;
        for (int j = 0; j < DIV_Q; j++) begin
            if (j == 0) begin
                rem  = DIV_R'(i_num[DIV_N-1:DIV_Q]);
                bits = i_num[DIV_Q-1:0];
                den  = i_den;
                quo  = '0;
            end else begin
                rem  = r_rem[j-1];
                bits = r_bits[j-1];
                den  = r_den[j-1];
                quo  = r_quo[j-1];
            end
            rem = {rem[DIV_R-2:0], bits[DIV_Q-1]};
            if (rem >= DIV_R'(den)) begin
                rem = rem - DIV_R'(den);
                quo = {quo[DIV_Q-2:0], 1'b1};
            end else begin
                quo = {quo[DIV_Q-2:0], 1'b0};
            end
            n_rem[j]  = rem;
            n_bits[j] = {bits[DIV_Q-2:0], 1'b0};
            n_den[j]  = den;
            n_quo[j]  = quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_bits <= n_bits;
            r_den  <= n_den;
            r_quo  <= n_quo;
        end
    end

    assign o_quot = r_quo[DIV_Q-1];

endmodule

// ===== hw/rtl/dec_dly.sv =====
module dec_dly import dec_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_item   i_item,
    output logic    o_valid,
    output t_item   o_item
);

    logic [LONG_LAT-1:0] r_vld;
    t_item               r_item [LONG_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[LONG_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item[0] <= i_item;
            for (int j = 1; j < LONG_LAT; j++) begin
                r_item[j] <= r_item[j-1];
            end
        end
    end

    assign o_valid = r_vld[LONG_LAT-1];
    assign o_item  = r_item[LONG_LAT-1];

endmodule

// ===== hw/rtl/dec_rot.sv =====
module dec_rot import dec_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  t_item               i_item,
    input  logic [DIV_Q-1:0]    i_nx_mag,
    input  logic [DIV_Q-1:0]    i_ny_mag,
    output logic                o_valid,
    output t_item               o_item,
    output logic [DIV_N-1:0]    o_rnum,
    output logic [DIV_D-1:0]    o_rden
);

    localparam int PW = WORD_W + NRM_W;

    logic                  r1_vld, r2_vld, r3_vld, r4_vld;
    t_item                 r1_item, r2_item, r3_item, r4_item;
    logic signed [PW-1:0]  r2_u1a, r2_u1b, r2_t1a, r2_t1b;
    logic signed [PW-1:0]  r2_u2a, r2_u2b, r2_t2a, r2_t2b;
    logic [DIV_N-1:0]      r4_num;
    logic [DIV_D-1:0]      r4_den;

    t_item                 c1_item, c3_item, c4_item;
    t_nrm                  mx, my;
    logic signed [PW:0]    su1, st1, su2, st2;
    logic [ROT_W-1:0]      ma, mb;
    logic [DIV_D-1:0]      asum;

    always_comb begin
        mx = t_nrm'(i_nx_mag[NRM_W-1:0]);
        my = t_nrm'(i_ny_mag[NRM_W-1:0]);
        c1_item = i_item;
        if (i_item.dlen == '0) begin
            c1_item.nx = NRM_ONE;
            c1_item.ny = '0;
        end else begin
            c1_item.nx = i_item.sx ? -mx : mx;
            c1_item.ny = i_item.sy ? -my : my;
        end

        su1 = (PW+1)'(r2_u1a) + (PW+1)'(r2_u1b);
        st1 = (PW+1)'(r2_t1a) - (PW+1)'(r2_t1b);
        su2 = (PW+1)'(r2_u2a) + (PW+1)'(r2_u2b);
        st2 = (PW+1)'(r2_t2a) - (PW+1)'(r2_t2b);
        c3_item = r2_item;
        c3_item.b  = t_rot'(su1[PW:FRAC]);
        c3_item.t1 = t_rot'(st1[PW:FRAC]);
        c3_item.a  = t_rot'(su2[PW:FRAC]);
        c3_item.t2 = t_rot'(st2[PW:FRAC]);

        ma = r3_item.a[ROT_W-1] ? ROT_W'(-r3_item.a) : ROT_W'(r3_item.a);
        mb = r3_item.b[ROT_W-1] ? ROT_W'(-r3_item.b) : ROT_W'(r3_item.b);
        asum = DIV_D'(ma) + DIV_D'(mb);
        c4_item = r3_item;
        c4_item.skip = (asum == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_item <= c1_item;
            r2_item <= r1_item;
            r2_u1a  <= r1_item.v1x * r1_item.nx;
            r2_u1b  <= r1_item.v1y * r1_item.ny;
            r2_t1a  <= r1_item.v1y * r1_item.nx;
            r2_t1b  <= r1_item.v1x * r1_item.ny;
            r2_u2a  <= r1_item.v2x * r1_item.nx;
            r2_u2b  <= r1_item.v2y * r1_item.ny;
            r2_t2a  <= r1_item.v2y * r1_item.nx;
            r2_t2b  <= r1_item.v2x * r1_item.ny;
            r3_item <= c3_item;
            r4_item <= c4_item;
            r4_num  <= DIV_N'({ma, {FRAC{1'b0}}});
            r4_den  <= asum;
        end
    end

    assign o_valid = r4_vld;
    assign o_item  = r4_item;
    assign o_rnum  = r4_num;
    assign o_rden  = r4_den;

endmodule

// ===== hw/rtl/dec_push.sv =====
module dec_push import dec_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  t_item               i_item,
    input  logic [DIV_Q-1:0]    i_qm,
    output logic                o_valid,
    output t_res                o_res
);

    localparam int PQ = Q_W + NRM_W;
    localparam int PR = ROT_W + NRM_W;
    localparam int HW = PQ - FRAC;

    logic                    r1_vld, r2_vld, r3_vld;
    t_item                   r1_item, r2_item;
    logic signed [PQ-1:0]    r1_qnx, r1_qny;
    logic signed [PR-1:0]    r1_anx, r1_t1ny, r1_t1nx, r1_any;
    logic signed [PR-1:0]    r1_bnx, r1_t2ny, r1_t2nx, r1_bny;
    logic signed [SAT_W-1:0] r2_px, r2_py, r2_v1x, r2_v1y, r2_v2x, r2_v2y;
    t_res                    r3_res;

    logic signed [Q_W-1:0]   q;
    logic signed [HW-1:0]    hx, hy;
    logic signed [PR:0]      d1x, d1y, d2x, d2y;
    t_res                    c_res;

    always_comb begin
        q = signed'(Q_W'(i_qm));
        if (i_item.a[ROT_W-1]) begin
            q = -q;
        end
        if (i_item.skip) begin
            q = '0;
        end

        hx  = r1_qnx[PQ-1:FRAC];
        hy  = r1_qny[PQ-1:FRAC];
        d1x = (PR+1)'(r1_anx)  - (PR+1)'(r1_t1ny);
        d1y = (PR+1)'(r1_t1nx) + (PR+1)'(r1_any);
        d2x = (PR+1)'(r1_bnx)  - (PR+1)'(r1_t2ny);
        d2y = (PR+1)'(r1_t2nx) + (PR+1)'(r1_bny);

        if (r2_item.hit) begin
            c_res.collided = 1'b1;
            c_res.npx      = sat_word(r2_px);
            c_res.npy      = sat_word(r2_py);
            c_res.nv1x     = sat_word(r2_v1x);
            c_res.nv1y     = sat_word(r2_v1y);
            c_res.nv2x     = sat_word(r2_v2x);
            c_res.nv2y     = sat_word(r2_v2y);
            c_res.skipped  = r2_item.skip;
        end else begin
            c_res.collided = 1'b0;
            c_res.npx      = r2_item.p1x;
            c_res.npy      = r2_item.p1y;
            c_res.nv1x     = r2_item.v1x;
            c_res.nv1y     = r2_item.v1y;
            c_res.nv2x     = r2_item.v2x;
            c_res.nv2y     = r2_item.v2y;
            c_res.skipped  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_item <= i_item;
            r1_qnx  <= q * i_item.nx;
            r1_qny  <= q * i_item.ny;
            r1_anx  <= i_item.a * i_item.nx;
            r1_t1ny <= i_item.t1 * i_item.ny;
            r1_t1nx <= i_item.t1 * i_item.nx;
            r1_any  <= i_item.a * i_item.ny;
            r1_bnx  <= i_item.b * i_item.nx;
            r1_t2ny <= i_item.t2 * i_item.ny;
            r1_t2nx <= i_item.t2 * i_item.nx;
            r1_bny  <= i_item.b * i_item.ny;
            r2_item <= r1_item;
            r2_px   <= SAT_W'(r1_item.p1x) + SAT_W'(hx);
            r2_py   <= SAT_W'(r1_item.p1y) + SAT_W'(hy);
            r2_v1x  <= d1x[PR:FRAC];
            r2_v1y  <= d1y[PR:FRAC];
            r2_v2x  <= d2x[PR:FRAC];
            r2_v2y  <= d2y[PR:FRAC];
            r3_res  <= c_res;
        end
    end

    assign o_valid = r3_vld;
    assign o_res   = r3_res;

endmodule
